// ----- hw/rtl/ksa_pkg.sv -----
package ksa_pkg;

    localparam int VAL_W = 32;
    localparam int SID_W = 2;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_UPDATE = 1'b1
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ----- hw/rtl/ksa_req_if.sv -----
interface ksa_req_if;
    import ksa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [SID_W-1:0]        stack_id;
    logic signed [VAL_W-1:0] push_value;

    modport source (output valid, output req_type, output stack_id, output push_value,
                    input ready);
    modport sink (input valid, input req_type, input stack_id, input push_value,
                  output ready);

endinterface

// ----- hw/rtl/ksa_rsp_if.sv -----
interface ksa_rsp_if;
    import ksa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] popped_value;

    modport source (output valid, output status, output popped_value, input ready);
    modport sink (input valid, input status, input popped_value, output ready);

endinterface

// ----- hw/rtl/k_stacks_shared_array.sv -----
// The result of an accepted beat is registered on the output when its update step commits,
// and the update step waits while an earlier result still waits on the output.
// A new beat is accepted only once the previous one has committed, since the registered read of
// the shared entry RAM must return the link before the stack and free pointers are updated.
// A result waiting on the output does not block the next request from being accepted.
// Reset is synchronous and active low: every stack becomes empty and the free list restarts
// at entry 0; a fill mark replaces any clearing pass, so the block is ready right after reset.
module k_stacks_shared_array #(
    parameter int DEPTH  = 512,
    parameter int STACKS = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ksa_req_if.sink   i_req,
    ksa_rsp_if.source o_rsp
);
    import ksa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ksa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ksa_dp #(
        .DEPTH  (DEPTH),
        .STACKS (STACKS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

// ----- hw/rtl/ksa_ram.sv -----
module ksa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hw/rtl/ksa_ctrl.sv -----
module ksa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ksa_pkg::t_sts i_sts,
    output ksa_pkg::t_cmd o_cmd
);
    import ksa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.in_ready = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.commit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_rst_n) begin
                    o_cmd.in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A captured beat must reach the update step before anything else is accepted.
    a_capture_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_UPDATE) && !o_cmd.in_ready)
        else $error("capture not followed by update");

endmodule

// ----- hw/rtl/ksa_dp.sv -----
module ksa_dp #(
    parameter int DEPTH  = 512,
    parameter int STACKS = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ksa_pkg::t_cmd i_cmd,
    output ksa_pkg::t_sts o_sts,
    ksa_req_if.sink       i_req,
    ksa_rsp_if.source     o_rsp
);
    import ksa_pkg::*;

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int NT = (STACKS < (1 << SID_W)) ? STACKS : (1 << SID_W);
    localparam int TW = (NT > 1) ? $clog2(NT) : 1;
    localparam int EW = VAL_W + PW;
    localparam logic [PW-1:0] NULLP = PW'(DEPTH);

    // Entries at or above r_fill have never been allocated and still chain to the next index.
    logic [PW-1:0]    r_top [NT];
    logic [PW-1:0]    r_free;
    logic [PW-1:0]    r_fill;
    logic             r_out_valid;

    logic             r_pop;
    logic             r_fail;
    logic [TW-1:0]    r_sid;
    logic [VAL_W-1:0] r_val;
    logic [PW-1:0]    r_slot;
    logic [1:0]       r_status;
    logic [VAL_W-1:0] r_popped;

    logic             sid_ok;
    logic [PW-1:0]    slot;
    logic [AW-1:0]    rd_addr;
    logic [EW-1:0]    rd_data;
    logic [EW-1:0]    wr_data;
    logic             we;
    logic [VAL_W-1:0] rd_val;
    logic [PW-1:0]    rd_link;
    logic             fresh;
    logic [PW-1:0]    next_free;
    logic [1:0]       n_status;
    logic [VAL_W-1:0] n_popped;

    always_comb begin
        sid_ok    = int'(i_req.stack_id) < STACKS;
        slot      = (i_req.req_type == REQ_POP) ? r_top[i_req.stack_id[TW-1:0]] : r_free;
        rd_addr   = i_cmd.in_ready ? slot[AW-1:0] : r_slot[AW-1:0];
        rd_val    = rd_data[EW-1:PW];
        rd_link   = rd_data[PW-1:0];
        fresh     = (r_slot == r_fill);
        next_free = fresh ? (r_slot + PW'(1)) : rd_link;
        we        = i_cmd.commit && !r_fail;
        wr_data   = r_pop ? {rd_val, r_free} : {r_val, r_top[r_sid]};
        if (r_fail) begin
            n_status = r_pop ? ST_UNDERFLOW : ST_OVERFLOW;
        end else begin
            n_status = ST_OK;
        end
        n_popped  = (!r_fail && r_pop) ? rd_val : '0;
    end

    ksa_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_slot[AW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NT; i++) begin
                r_top[i] <= NULLP;
            end
            r_free      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (we) begin
                if (r_pop) begin
                    r_top[r_sid] <= rd_link;
                    r_free       <= r_slot;
                end else begin
                    r_top[r_sid] <= r_slot;
                    r_free       <= next_free;
                    if (fresh) begin
                        r_fill <= r_fill + PW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pop  <= (i_req.req_type == REQ_POP);
            r_sid  <= i_req.stack_id[TW-1:0];
            r_val  <= i_req.push_value;
            r_slot <= slot;
            r_fail <= !sid_ok || (slot >= NULLP);
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    assign o_sts.out_free     = !r_out_valid || o_rsp.ready;
    assign i_req.ready        = i_cmd.in_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.popped_value = r_popped;

    // The free head never points past the allocation mark unless the store is exhausted.
    a_free_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free <= r_fill) || (r_free == NULLP))
        else $error("free head beyond allocation mark");

    a_fail_keeps_lists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_fail |=> $stable(r_free) && $stable(r_fill))
        else $error("rejected beat changed the free list");

    a_push_sets_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && !r_fail && !r_pop |=> r_top[$past(r_sid)] == $past(r_slot))
        else $error("push did not move the stack top");

endmodule
